// ===== rtl/pvu_pkg.sv =====
// Shared types and codes for the particle velocity update block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package pvu_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// input command codes
	localparam logic [1:0] CMD_SET_POS = 2'd0;
	localparam logic [1:0] CMD_SET_VEL = 2'd1;
	localparam logic [1:0] CMD_ADD_ACC = 2'd2;
	localparam logic [1:0] CMD_STEP    = 2'd3;

	// datapath operation codes
	localparam logic [5:0] OP_NOP       = 6'd0;
	localparam logic [5:0] OP_LOAD_POS  = 6'd1;
	localparam logic [5:0] OP_LOAD_VEL  = 6'd2;
	localparam logic [5:0] OP_ADD_ACC   = 6'd3;
	localparam logic [5:0] OP_LATCH     = 6'd4;
	localparam logic [5:0] OP_DIFF      = 6'd5;
	localparam logic [5:0] OP_MUL_SQ_D  = 6'd6;
	localparam logic [5:0] OP_MUL_SQ_V  = 6'd7;
	localparam logic [5:0] OP_ACC_LSQ   = 6'd8;
	localparam logic [5:0] OP_SQRT      = 6'd9;
	localparam logic [5:0] OP_MUL_PULL  = 6'd10;
	localparam logic [5:0] OP_PULL_M    = 6'd11;
	localparam logic [5:0] OP_MUL_DM    = 6'd12;
	localparam logic [5:0] OP_DIV       = 6'd13;
	localparam logic [5:0] OP_PULL_UPD  = 6'd14;
	localparam logic [5:0] OP_TGT_MUL   = 6'd15;
	localparam logic [5:0] OP_TGT       = 6'd16;
	localparam logic [5:0] OP_CROWD_MUL = 6'd17;
	localparam logic [5:0] OP_CROWD     = 6'd18;
	localparam logic [5:0] OP_FEAR_MUL  = 6'd19;
	localparam logic [5:0] OP_FEAR      = 6'd20;
	localparam logic [5:0] OP_ACCEL     = 6'd21;
	localparam logic [5:0] OP_MAXS      = 6'd22;
	localparam logic [5:0] OP_MUL_MAX   = 6'd23;
	localparam logic [5:0] OP_CMP_MAX   = 6'd24;
	localparam logic [5:0] OP_MUL_MIN   = 6'd25;
	localparam logic [5:0] OP_CMP_MIN   = 6'd26;
	localparam logic [5:0] OP_SEL_TGT   = 6'd27;
	localparam logic [5:0] OP_ZERO_VEL  = 6'd28;
	localparam logic [5:0] OP_MUL_VT    = 6'd29;
	localparam logic [5:0] OP_SET_VEL   = 6'd30;
	localparam logic [5:0] OP_MUL_FV    = 6'd31;
	localparam logic [5:0] OP_VEL_MULQ  = 6'd32;
	localparam logic [5:0] OP_MOVE      = 6'd33;
	localparam logic [5:0] OP_MUL_DEC   = 6'd34;
	localparam logic [5:0] OP_FINISH    = 6'd35;

	typedef struct packed {
		logic [5:0] op;
		logic [1:0] idx;
	} pvu_cmd_t;

	typedef struct packed {
		logic pull;
		logic sqrt_done;
		logic div_done;
		logic root_gt;
		logic root_zero;
		logic gt_max;
		logic lt_min;
		logic out_full;
	} pvu_sts_t;

	typedef struct packed {
		logic [30:0]        max_speed;
		logic [30:0]        min_speed;
		logic [16:0]        decay;
		logic [30:0]        pull_radius;
		logic [16:0]        pull_gain;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
	} pvu_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/particle_velocity_update.sv =====
// Top level of the particle velocity update block: APB register file,
// sequencer and datapath. Depends on pvu_pkg, pvu_ctrl and pvu_dp.
`default_nettype none
// One flocking particle in Q(32-FRAC_BITS).FRAC_BITS fixed point. Set-position,
// set-velocity and add-acceleration commands give no result beat. A step runs
// the center pull when it is active and the particle lies outside the pull
// radius, and clamps the speed when it must; both use the shared radix-2
// divider for each of the three components and the square root unit. One item
// is in work at a time; in_stall is high from a step's acceptance until its
// result sits in the output register, which holds it until the receiver takes
// it. The configuration registers sit at byte addresses 4*i and reset to their
// nominal values.
module particle_velocity_update #(
	parameter int FRAC_BITS = pvu_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic [7:0]         neighbor_count,
	input  wire logic               flatten,
	input  wire logic               pull_enable,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic signed [31:0]      vel_z,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import pvu_pkg::*;

	localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
	localparam logic [2:0] REG_MIN_SPEED   = 3'd1;
	localparam logic [2:0] REG_DECAY       = 3'd2;
	localparam logic [2:0] REG_PULL_RADIUS = 3'd3;
	localparam logic [2:0] REG_PULL_GAIN   = 3'd4;
	localparam logic [2:0] REG_CENTER_X    = 3'd5;
	localparam logic [2:0] REG_CENTER_Y    = 3'd6;
	localparam logic [2:0] REG_CENTER_Z    = 3'd7;

	pvu_cfg_t   cfg_q;
	pvu_cmd_t   dp_cmd;
	pvu_sts_t   dp_sts;
	logic       busy;
	logic       cfg_wr;
	logic       in_take;
	logic [1:0] ctrl_cmd;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign in_take = in_valid && !busy;
	assign ctrl_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed   <= 31'd196608;
			cfg_q.min_speed   <= 31'd81920;
			cfg_q.decay       <= 17'd64881;
			cfg_q.pull_radius <= 31'd6553600;
			cfg_q.pull_gain   <= 17'd655;
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.center_z    <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MAX_SPEED:   cfg_q.max_speed   <= pwdata[30:0];
				REG_MIN_SPEED:   cfg_q.min_speed   <= pwdata[30:0];
				REG_DECAY:       cfg_q.decay       <= pwdata[16:0];
				REG_PULL_RADIUS: cfg_q.pull_radius <= pwdata[30:0];
				REG_PULL_GAIN:   cfg_q.pull_gain   <= pwdata[16:0];
				REG_CENTER_X:    cfg_q.center_x    <= pwdata;
				REG_CENTER_Y:    cfg_q.center_y    <= pwdata;
				REG_CENTER_Z:    cfg_q.center_z    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MAX_SPEED:   prdata = 32'(cfg_q.max_speed);
			REG_MIN_SPEED:   prdata = 32'(cfg_q.min_speed);
			REG_DECAY:       prdata = 32'(cfg_q.decay);
			REG_PULL_RADIUS: prdata = 32'(cfg_q.pull_radius);
			REG_PULL_GAIN:   prdata = 32'(cfg_q.pull_gain);
			REG_CENTER_X:    prdata = cfg_q.center_x;
			REG_CENTER_Y:    prdata = cfg_q.center_y;
			REG_CENTER_Z:    prdata = cfg_q.center_z;
			default:         prdata = '0;
		endcase
	end

	pvu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_take),
		.cmd_in    (ctrl_cmd),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd       (dp_cmd),
		.busy      (busy)
	);

	pvu_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.cfg            (cfg_q),
		.vec_x          (vec_x),
		.vec_y          (vec_y),
		.vec_z          (vec_z),
		.neighbor_count (neighbor_count),
		.flatten        (flatten),
		.pull_enable    (pull_enable),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.vel_z          (vel_z),
		.sts            (dp_sts)
	);

	assign in_stall = busy;
endmodule
`default_nettype wire

// ===== rtl/pvu_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Standalone; used by the datapath.
`default_nettype none
module pvu_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic      [31:0] root,
	output logic             done
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] cand;
	logic [35:0] trial;
	logic        ge;

	assign cand  = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(cand - trial) : cand[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/pvu_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Standalone; used by the datapath.
`default_nettype none
module pvu_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic      [63:0] quot,
	output logic             done
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] r;
	logic        ge;

	assign r  = {rem_q, num_q[63]};
	assign ge = r >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r - {1'b0, den_q}) : r[31:0];
			num_q <= {num_q[62:0], ge};
		end
	end

	assign quot = num_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/pvu_dp.sv =====
// Datapath: particle state, shared multiplier, square root and divider units.
// Depends on pvu_pkg, pvu_sqrt and pvu_div; driven by pvu_ctrl.
`default_nettype none
module pvu_dp #(
	parameter int FRAC_BITS = pvu_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pvu_pkg::pvu_cmd_t  cmd,
	input  wire pvu_pkg::pvu_cfg_t  cfg,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic [7:0]         neighbor_count,
	input  wire logic               flatten,
	input  wire logic               pull_enable,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic signed [31:0]      vel_z,
	output pvu_pkg::pvu_sts_t       sts
);
	import pvu_pkg::*;

	localparam int CW = FRAC_BITS + 2;
	localparam logic [CW-1:0] ONE_Q  = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic [CW-1:0] HALF_Q = {3'b001, {(FRAC_BITS - 1){1'b0}}};
	localparam int K002_I = ((1 << FRAC_BITS) + 25) / 50;
	localparam int K01_I  = ((1 << FRAC_BITS) + 5) / 10;
	localparam int K08_I  = ((4 << FRAC_BITS) + 2) / 5;
	localparam logic signed [65:0] RND   = 66'(HALF_Q);
	localparam logic signed [65:0] MAX66 = 66'sd2147483647;
	localparam logic signed [65:0] MIN66 = -66'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > MAX66)
			return 32'sh7FFF_FFFF;
		if (v < MIN66)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [65:0] mulq(input logic signed [65:0] p);
		return (p + RND) >>> FRAC_BITS;
	endfunction

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];
	logic [CW-1:0]      crowd_q;
	logic [CW-1:0]      fear_q;
	logic               out_valid_q;

	logic signed [31:0] d_q [3];
	logic signed [31:0] out_pos_q [3];
	logic signed [31:0] out_vel_q [3];
	logic signed [65:0] prod_s1;
	logic [63:0]        lsq_q;
	logic [31:0]        root_q;
	logic [31:0]        m_q;
	logic [31:0]        maxs_q;
	logic signed [32:0] tgt_q;
	logic signed [31:0] quot_q;
	logic               div_neg_q;
	logic               gt_max_q;
	logic               lt_min_q;
	logic [7:0]         nb_q;
	logic               flat_q;
	logic               pull_q;

	logic signed [31:0] vec_in [3];
	logic signed [31:0] center [3];
	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [65:0] pmq;
	logic signed [33:0] cr_new;
	logic [63:0]        div_num;
	logic [31:0]        sqrt_root;
	logic               sqrt_done;
	logic [63:0]        div_quot;
	logic               div_done;
	logic signed [65:0] quot_val;

	assign vec_in[0] = vec_x;
	assign vec_in[1] = vec_y;
	assign vec_in[2] = vec_z;
	assign center[0] = cfg.center_x;
	assign center[1] = cfg.center_y;
	assign center[2] = cfg.center_z;

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MUL_SQ_D: begin
				ma = 33'(d_q[cmd.idx]);
				mb = 33'(d_q[cmd.idx]);
			end
			OP_MUL_SQ_V: begin
				ma = 33'(vel_q[cmd.idx]);
				mb = 33'(vel_q[cmd.idx]);
			end
			OP_MUL_PULL: begin
				ma = $signed({1'b0, root_q} - {2'b00, cfg.pull_radius});
				mb = $signed(33'(cfg.pull_gain));
			end
			OP_MUL_DM: begin
				ma = 33'(d_q[cmd.idx]);
				mb = $signed({1'b0, m_q});
			end
			OP_TGT_MUL: begin
				ma = $signed(33'(nb_q));
				mb = 33'(K002_I);
			end
			OP_CROWD_MUL: begin
				ma = $signed(33'(crowd_q)) - tgt_q;
				mb = 33'(K01_I);
			end
			OP_FEAR_MUL: begin
				ma = $signed(33'(fear_q));
				mb = 33'(K08_I);
			end
			OP_MUL_MAX: begin
				ma = $signed({1'b0, maxs_q});
				mb = $signed({1'b0, maxs_q});
			end
			OP_MUL_MIN: begin
				ma = $signed({2'b00, cfg.min_speed});
				mb = $signed({2'b00, cfg.min_speed});
			end
			OP_MUL_VT: begin
				ma = 33'(vel_q[cmd.idx]);
				mb = $signed({1'b0, m_q});
			end
			OP_MUL_FV: begin
				ma = 33'(vel_q[cmd.idx]);
				mb = $signed(33'(ONE_Q + fear_q));
			end
			OP_MUL_DEC: begin
				ma = 33'(vel_q[cmd.idx]);
				mb = $signed(33'(cfg.decay));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign pmq      = mulq(prod_s1);
	assign cr_new   = $signed(34'(crowd_q)) - 34'(pmq);
	assign div_num  = prod_s1[65] ? 64'(-prod_s1) : prod_s1[63:0];
	assign quot_val = div_neg_q ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});

	pvu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT),
		.radicand (lsq_q),
		.root     (sqrt_root),
		.done     (sqrt_done)
	);

	pvu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV),
		.num    (div_num),
		.den    (root_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	// architectural particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
			crowd_q     <= ONE_Q;
			fear_q      <= ONE_Q;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD_POS: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= vec_in[i];
						acc_q[i] <= '0;
					end
					crowd_q <= ONE_Q;
					fear_q  <= ONE_Q;
				end
				OP_LOAD_VEL: begin
					for (int i = 0; i < 3; i++)
						vel_q[i] <= vec_in[i];
				end
				OP_ADD_ACC: begin
					for (int i = 0; i < 3; i++)
						acc_q[i] <= sat32(66'(acc_q[i]) + 66'(vec_in[i]));
				end
				OP_PULL_UPD: vel_q[cmd.idx] <= sat32(66'(vel_q[cmd.idx]) - 66'(quot_q));
				OP_CROWD: begin
					if (cr_new < $signed(34'(ONE_Q >> 1)))
						crowd_q <= ONE_Q >> 1;
					else if (cr_new > $signed(34'(ONE_Q)))
						crowd_q <= ONE_Q;
					else
						crowd_q <= cr_new[CW-1:0];
				end
				OP_FEAR: fear_q <= CW'(pmq);
				OP_ACCEL: begin
					// z of acceleration drops out when flattening
					for (int i = 0; i < 3; i++) begin
						if (flat_q && i == 2) begin
							acc_q[i] <= '0;
						end else begin
							vel_q[i] <= sat32(66'(vel_q[i]) + 66'(acc_q[i]));
						end
					end
				end
				OP_ZERO_VEL: begin
					for (int i = 0; i < 3; i++)
						vel_q[i] <= '0;
				end
				OP_SET_VEL:  vel_q[cmd.idx] <= quot_q;
				OP_VEL_MULQ: vel_q[cmd.idx] <= sat32(pmq);
				OP_MOVE: begin
					for (int i = 0; i < 3; i++)
						pos_q[i] <= sat32(66'(pos_q[i]) + 66'(vel_q[i]));
					if (flat_q)
						pos_q[2] <= '0;
				end
				OP_FINISH: begin
					for (int i = 0; i < 3; i++)
						acc_q[i] <= '0;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (sqrt_done)
			root_q <= sqrt_root;
		if (div_done)
			quot_q <= sat32(quot_val);
		case (cmd.op)
			OP_LATCH: begin
				nb_q   <= neighbor_count;
				flat_q <= flatten;
				pull_q <= pull_enable;
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++)
					d_q[i] <= sat32(66'(pos_q[i]) - 66'(center[i]));
				lsq_q <= '0;
			end
			OP_ACC_LSQ: lsq_q <= lsq_q + prod_s1[63:0];
			OP_PULL_M:  m_q <= (pmq > MAX66) ? 32'h7FFF_FFFF : pmq[31:0];
			OP_DIV:     div_neg_q <= prod_s1[65];
			OP_TGT:     tgt_q <= $signed(33'(ONE_Q)) - $signed(prod_s1[32:0]);
			OP_ACCEL:   lsq_q <= '0;
			OP_MAXS:    maxs_q <= 32'(cfg.max_speed) + 32'(crowd_q);
			OP_CMP_MAX: gt_max_q <= lsq_q > prod_s1[63:0];
			OP_CMP_MIN: lt_min_q <= lsq_q < prod_s1[63:0];
			OP_SEL_TGT: m_q <= gt_max_q ? maxs_q : {1'b0, cfg.min_speed};
			OP_FINISH: begin
				for (int i = 0; i < 3; i++) begin
					out_pos_q[i] <= pos_q[i];
					out_vel_q[i] <= vel_q[i];
				end
			end
			default: ;
		endcase
	end

	assign sts.pull      = pull_q;
	assign sts.sqrt_done = sqrt_done;
	assign sts.div_done  = div_done;
	assign sts.root_gt   = root_q > {1'b0, cfg.pull_radius};
	assign sts.root_zero = root_q == '0;
	assign sts.gt_max    = gt_max_q;
	assign sts.lt_min    = lt_min_q;
	assign sts.out_full  = out_valid_q;

	assign out_valid = out_valid_q;
	assign pos_x = out_pos_q[0];
	assign pos_y = out_pos_q[1];
	assign pos_z = out_pos_q[2];
	assign vel_x = out_vel_q[0];
	assign vel_y = out_vel_q[1];
	assign vel_z = out_vel_q[2];
endmodule
`default_nettype wire

// ===== rtl/pvu_ctrl.sv =====
// Particle update sequencer: issues at most one datapath operation per cycle
// Depends on pvu_pkg; drives pvu_dp.
`default_nettype none
module pvu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        cmd_in,
	input  wire logic              out_stall,
	input  wire pvu_pkg::pvu_sts_t sts,
	output pvu_pkg::pvu_cmd_t      cmd,
	output logic                   busy
);
	import pvu_pkg::*;

	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] S_PDIFF = 6'd1;
	localparam logic [5:0] S_PSQ   = 6'd2;
	localparam logic [5:0] S_PACC  = 6'd3;
	localparam logic [5:0] S_PSQRT = 6'd4;
	localparam logic [5:0] S_PSQW  = 6'd5;
	localparam logic [5:0] S_PTEST = 6'd6;
	localparam logic [5:0] S_PM    = 6'd7;
	localparam logic [5:0] S_PDM   = 6'd8;
	localparam logic [5:0] S_PDIV  = 6'd9;
	localparam logic [5:0] S_PDIVW = 6'd10;
	localparam logic [5:0] S_PUPD  = 6'd11;
	localparam logic [5:0] S_TGTM  = 6'd12;
	localparam logic [5:0] S_TGT   = 6'd13;
	localparam logic [5:0] S_CRM   = 6'd14;
	localparam logic [5:0] S_CR    = 6'd15;
	localparam logic [5:0] S_FM    = 6'd16;
	localparam logic [5:0] S_FR    = 6'd17;
	localparam logic [5:0] S_ACCEL = 6'd18;
	localparam logic [5:0] S_VSQ   = 6'd19;
	localparam logic [5:0] S_VACC  = 6'd20;
	localparam logic [5:0] S_MAXS  = 6'd21;
	localparam logic [5:0] S_MXM   = 6'd22;
	localparam logic [5:0] S_MXC   = 6'd23;
	localparam logic [5:0] S_MNM   = 6'd24;
	localparam logic [5:0] S_MNC   = 6'd25;
	localparam logic [5:0] S_SEL   = 6'd26;
	localparam logic [5:0] S_SQRT  = 6'd27;
	localparam logic [5:0] S_SQW   = 6'd28;
	localparam logic [5:0] S_ZCHK  = 6'd29;
	localparam logic [5:0] S_VTM   = 6'd30;
	localparam logic [5:0] S_VDIV  = 6'd31;
	localparam logic [5:0] S_VDIVW = 6'd32;
	localparam logic [5:0] S_VSET  = 6'd33;
	localparam logic [5:0] S_FVM   = 6'd34;
	localparam logic [5:0] S_FVQ   = 6'd35;
	localparam logic [5:0] S_MOVE  = 6'd36;
	localparam logic [5:0] S_DM    = 6'd37;
	localparam logic [5:0] S_DQ    = 6'd38;
	localparam logic [5:0] S_FIN   = 6'd39;

	logic [5:0] state_q;
	logic [5:0] state_d;
	logic [1:0] idx_q;
	logic [1:0] idx_d;
	logic       last;

	assign last = idx_q == 2'd2;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd.op  = OP_NOP;
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd_in)
						CMD_SET_POS: cmd.op = OP_LOAD_POS;
						CMD_SET_VEL: cmd.op = OP_LOAD_VEL;
						CMD_ADD_ACC: cmd.op = OP_ADD_ACC;
						CMD_STEP: begin
							cmd.op  = OP_LATCH;
							state_d = S_PDIFF;
						end
						default: cmd.op = OP_NOP;
					endcase
				end
			end
			S_PDIFF: begin
				idx_d = 2'd0;
				if (sts.pull) begin
					cmd.op  = OP_DIFF;
					state_d = S_PSQ;
				end else begin
					state_d = S_TGTM;
				end
			end
			S_PSQ: begin
				cmd.op  = OP_MUL_SQ_D;
				state_d = S_PACC;
			end
			S_PACC: begin
				cmd.op  = OP_ACC_LSQ;
				idx_d   = idx_q + 2'd1;
				state_d = last ? S_PSQRT : S_PSQ;
			end
			S_PSQRT: begin
				cmd.op  = OP_SQRT;
				state_d = S_PSQW;
			end
			S_PSQW: if (sts.sqrt_done) state_d = S_PTEST;
			S_PTEST: begin
				cmd.op  = OP_MUL_PULL;
				idx_d   = 2'd0;
				state_d = sts.root_gt ? S_PM : S_TGTM;
			end
			S_PM: begin
				cmd.op  = OP_PULL_M;
				state_d = S_PDM;
			end
			S_PDM: begin
				cmd.op  = OP_MUL_DM;
				state_d = S_PDIV;
			end
			S_PDIV: begin
				cmd.op  = OP_DIV;
				state_d = S_PDIVW;
			end
			S_PDIVW: if (sts.div_done) state_d = S_PUPD;
			S_PUPD: begin
				cmd.op  = OP_PULL_UPD;
				idx_d   = idx_q + 2'd1;
				state_d = last ? S_TGTM : S_PDM;
			end
			S_TGTM: begin
				cmd.op  = OP_TGT_MUL;
				state_d = S_TGT;
			end
			S_TGT: begin
				cmd.op  = OP_TGT;
				state_d = S_CRM;
			end
			S_CRM: begin
				cmd.op  = OP_CROWD_MUL;
				state_d = S_CR;
			end
			S_CR: begin
				cmd.op  = OP_CROWD;
				state_d = S_FM;
			end
			S_FM: begin
				cmd.op  = OP_FEAR_MUL;
				state_d = S_FR;
			end
			S_FR: begin
				cmd.op  = OP_FEAR;
				state_d = S_ACCEL;
			end
			S_ACCEL: begin
				cmd.op  = OP_ACCEL;
				idx_d   = 2'd0;
				state_d = S_VSQ;
			end
			S_VSQ: begin
				cmd.op  = OP_MUL_SQ_V;
				state_d = S_VACC;
			end
			S_VACC: begin
				cmd.op  = OP_ACC_LSQ;
				idx_d   = idx_q + 2'd1;
				state_d = last ? S_MAXS : S_VSQ;
			end
			S_MAXS: begin
				cmd.op  = OP_MAXS;
				state_d = S_MXM;
			end
			S_MXM: begin
				cmd.op  = OP_MUL_MAX;
				state_d = S_MXC;
			end
			S_MXC: begin
				cmd.op  = OP_CMP_MAX;
				state_d = S_MNM;
			end
			S_MNM: begin
				cmd.op  = OP_MUL_MIN;
				state_d = S_MNC;
			end
			S_MNC: begin
				cmd.op  = OP_CMP_MIN;
				state_d = S_SEL;
			end
			S_SEL: begin
				cmd.op  = OP_SEL_TGT;
				idx_d   = 2'd0;
				state_d = (sts.gt_max || sts.lt_min) ? S_SQRT : S_FVM;
			end
			S_SQRT: begin
				cmd.op  = OP_SQRT;
				state_d = S_SQW;
			end
			S_SQW: if (sts.sqrt_done) state_d = S_ZCHK;
			S_ZCHK: begin
				// a zero vector normalizes to zero
				idx_d = 2'd0;
				if (sts.root_zero) begin
					cmd.op  = OP_ZERO_VEL;
					state_d = S_FVM;
				end else begin
					state_d = S_VTM;
				end
			end
			S_VTM: begin
				cmd.op  = OP_MUL_VT;
				state_d = S_VDIV;
			end
			S_VDIV: begin
				cmd.op  = OP_DIV;
				state_d = S_VDIVW;
			end
			S_VDIVW: if (sts.div_done) state_d = S_VSET;
			S_VSET: begin
				cmd.op  = OP_SET_VEL;
				idx_d   = last ? 2'd0 : idx_q + 2'd1;
				state_d = last ? S_FVM : S_VTM;
			end
			S_FVM: begin
				cmd.op  = OP_MUL_FV;
				state_d = S_FVQ;
			end
			S_FVQ: begin
				cmd.op  = OP_VEL_MULQ;
				idx_d   = last ? 2'd0 : idx_q + 2'd1;
				state_d = last ? S_MOVE : S_FVM;
			end
			S_MOVE: begin
				cmd.op  = OP_MOVE;
				state_d = S_DM;
			end
			S_DM: begin
				cmd.op  = OP_MUL_DEC;
				state_d = S_DQ;
			end
			S_DQ: begin
				cmd.op  = OP_VEL_MULQ;
				idx_d   = idx_q + 2'd1;
				state_d = last ? S_FIN : S_DM;
			end
			S_FIN: begin
				// hold until the output register frees up
				if (!sts.out_full || !out_stall) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign busy = state_q != S_IDLE;
endmodule
`default_nettype wire
